// ===== hdl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and score arithmetic for the boosted stump classifier.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam logic [2:0] CMD_CLEAR       = 3'd0;
	localparam logic [2:0] CMD_LOAD_STUMP  = 3'd1;
	localparam logic [2:0] CMD_LOAD_WEIGHT = 3'd2;
	localparam logic [2:0] CMD_FEATURE     = 3'd3;
	localparam logic [2:0] CMD_END         = 3'd4;

	localparam logic [1:0] SLOT_ABSENT = 2'd0;
	localparam logic [1:0] SLOT_BELOW  = 2'd1;
	localparam logic [1:0] SLOT_ABOVE  = 2'd2;

	localparam logic REG_LABELS = 1'b0;
	localparam logic REG_STUMPS = 1'b1;

	localparam int SCORE_W = 40;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_LOAD_STUMP,
		OP_LOAD_WEIGHT,
		OP_FEATURE,
		OP_END
	} op_t;

	// one classified item as it travels through the queue
	typedef struct packed {
		op_t                op;
		logic [7:0]         stump;
		logic [15:0]        feat;
		logic [2:0]         label;
		logic [1:0]         slot;
		logic signed [31:0] data;
	} item_t;

	typedef struct packed {
		logic        en;
		logic        idx;
		logic [31:0] data;
	} cfg_wr_t;

	// clamp a 41-bit sum to the 40-bit score range
	function automatic logic signed [SCORE_W-1:0] sat41(input logic signed [SCORE_W:0] v);
		logic signed [SCORE_W-1:0] r;
		if (v[SCORE_W] != v[SCORE_W-1]) begin
			r = v[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// Decodes input items, drops those that do nothing and pushes the rest.
// ----------------------------------------------------------------------------
module bsc_front import bsc_pkg::*; #(
	parameter int MAX_STUMPS = 256,
	parameter int MAX_LABELS = 8
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [7:0]         stump_index,
	input  logic [15:0]        feature_id,
	input  logic signed [31:0] threshold,
	input  logic [2:0]         label_index,
	input  logic [1:0]         weight_slot,
	input  logic signed [31:0] weight,
	input  logic signed [31:0] feature_value,
	input  logic               q_full,
	output logic               q_push,
	output item_t              q_item
);

	logic keep;
	logic stump_ok;

	assign stump_ok = 32'(stump_index) < MAX_STUMPS;

	always_comb begin
		q_item.op    = OP_CLEAR;
		q_item.stump = stump_index;
		q_item.feat  = feature_id;
		q_item.label = label_index;
		q_item.slot  = weight_slot;
		q_item.data  = feature_value;
		keep         = 1'b0;
		unique case (cmd)
			CMD_CLEAR: begin
				q_item.op = OP_CLEAR;
				keep      = 1'b1;
			end
			CMD_LOAD_STUMP: begin
				q_item.op   = OP_LOAD_STUMP;
				q_item.data = threshold;
				keep        = stump_ok;
			end
			CMD_LOAD_WEIGHT: begin
				q_item.op   = OP_LOAD_WEIGHT;
				q_item.data = weight;
				keep        = stump_ok && (32'(label_index) < MAX_LABELS) &&
				              (weight_slot == SLOT_ABSENT || weight_slot == SLOT_BELOW ||
				               weight_slot == SLOT_ABOVE);
			end
			CMD_FEATURE: begin
				q_item.op = OP_FEATURE;
				keep      = 1'b1;
			end
			CMD_END: begin
				q_item.op = OP_END;
				keep      = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

endmodule

// ===== hdl/bsc_queue.sv =====
// ----------------------------------------------------------------------------
// bsc_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bsc_queue import bsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hdl/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// Stump tables, score registers and the sequencer that scans the stumps.
// ----------------------------------------------------------------------------
module bsc_back import bsc_pkg::*; #(
	parameter int MAX_STUMPS   = 256,
	parameter int MAX_LABELS   = 8,
	parameter int FEATURE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  item_t                     q_head,
	output logic                      q_pop,
	input  cfg_wr_t                   cfg_wr,
	output logic [3:0]                labels_reg,
	output logic [8:0]                stumps_reg,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                predicted_label,
	output logic signed [SCORE_W-1:0] best_score
);

	localparam int SW  = (MAX_STUMPS > 1) ? $clog2(MAX_STUMPS) : 1;
	localparam int LW  = $clog2(MAX_LABELS);
	localparam int CSW = $clog2(MAX_STUMPS + 1);
	localparam int CLW = $clog2(MAX_LABELS + 1);
	localparam int WD  = MAX_STUMPS << LW;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_OPEN_RD  = 11'b000_0000_0010,
		S_OPEN_ADD = 11'b000_0000_0100,
		S_SCAN_RD  = 11'b000_0000_1000,
		S_SCAN_CHK = 11'b000_0001_0000,
		S_W_RD     = 11'b000_0010_0000,
		S_W_SUB    = 11'b000_0100_0000,
		S_W_ADD    = 11'b000_1000_0000,
		S_END_INIT = 11'b001_0000_0000,
		S_END_CMP  = 11'b010_0000_0000,
		S_EMIT     = 11'b100_0000_0000
	} state_t;

	// tables
	logic [FEATURE_BITS-1:0] feat_mem [MAX_STUMPS];
	logic signed [31:0]      thr_mem  [MAX_STUMPS];
	logic signed [31:0]      wabs_mem [WD];
	logic signed [31:0]      wblw_mem [WD];
	logic signed [31:0]      wabv_mem [WD];

	logic [FEATURE_BITS-1:0] feat_rd_q;
	logic signed [31:0]      thr_rd_q;
	logic signed [31:0]      wabs_rd_q;
	logic signed [31:0]      wblw_rd_q;
	logic signed [31:0]      wabv_rd_q;

	state_t                    state_q;
	logic [3:0]                labels_q;
	logic [8:0]                stumps_q;
	logic                      open_q;
	logic signed [SCORE_W-1:0] run_q [MAX_LABELS];
	logic [CSW-1:0]            s_q;
	logic [CLW-1:0]            l_q;
	op_t                       cur_op_q;
	logic [FEATURE_BITS-1:0]   cur_feat_q;
	logic signed [31:0]        cur_val_q;
	logic                      below_q;
	logic signed [SCORE_W-1:0] tmp_q;
	logic signed [SCORE_W-1:0] best_q;
	logic [LW-1:0]             best_lbl_q;
	logic                      res_valid_q;
	logic [2:0]                res_label_q;
	logic signed [SCORE_W-1:0] res_score_q;

	logic [CSW-1:0]          eff_ns;
	logic [CLW-1:0]          eff_nl;
	logic [SW-1:0]           ld_stump;
	logic [SW+LW-1:0]        ld_waddr;
	logic [SW+LW-1:0]        rd_waddr;
	logic                    emit_go;
	logic signed [SCORE_W-1:0] cur_run;
	logic signed [31:0]      w_pick;

	always_comb begin
		if (32'(labels_q) > MAX_LABELS) begin
			eff_nl = CLW'(MAX_LABELS);
		end else if (labels_q == 4'd0) begin
			eff_nl = CLW'(1);
		end else begin
			eff_nl = CLW'(labels_q);
		end
		if (32'(stumps_q) > MAX_STUMPS) begin
			eff_ns = CSW'(MAX_STUMPS);
		end else begin
			eff_ns = CSW'(stumps_q);
		end
	end

	assign ld_stump = SW'(32'(q_head.stump));
	assign ld_waddr = {ld_stump, LW'(32'(q_head.label))};
	assign rd_waddr = {s_q[SW-1:0], l_q[LW-1:0]};
	assign cur_run  = run_q[l_q[LW-1:0]];
	assign w_pick   = below_q ? wblw_rd_q : wabv_rd_q;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign emit_go  = (state_q == S_EMIT) && (!res_valid_q || !out_stall);

	// table write and read ports
	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == OP_LOAD_STUMP) begin
			feat_mem[ld_stump] <= FEATURE_BITS'(32'(q_head.feat));
			thr_mem[ld_stump]  <= q_head.data;
		end
		feat_rd_q <= feat_mem[s_q[SW-1:0]];
		thr_rd_q  <= thr_mem[s_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == OP_LOAD_WEIGHT) begin
			case (q_head.slot)
				SLOT_ABSENT: wabs_mem[ld_waddr] <= q_head.data;
				SLOT_BELOW:  wblw_mem[ld_waddr] <= q_head.data;
				default:     wabv_mem[ld_waddr] <= q_head.data;
			endcase
		end
		wabs_rd_q <= wabs_mem[rd_waddr];
		wblw_rd_q <= wblw_mem[rd_waddr];
		wabv_rd_q <= wabv_mem[rd_waddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			labels_q    <= 4'd8;
			stumps_q    <= 9'd0;
			open_q      <= 1'b0;
			s_q         <= '0;
			l_q         <= '0;
			cur_op_q    <= OP_CLEAR;
			res_valid_q <= 1'b0;
			for (int i = 0; i < MAX_LABELS; i++) begin
				run_q[i] <= '0;
			end
		end else begin
			if (cfg_wr.en) begin
				if (cfg_wr.idx == REG_LABELS) begin
					labels_q <= cfg_wr.data[3:0];
				end else begin
					stumps_q <= cfg_wr.data[8:0];
				end
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_op_q   <= q_head.op;
						cur_feat_q <= FEATURE_BITS'(32'(q_head.feat));
						cur_val_q  <= q_head.data;
						s_q        <= '0;
						l_q        <= '0;
						if (q_head.op == OP_CLEAR) begin
							open_q   <= 1'b0;
							stumps_q <= 9'd0;
							for (int i = 0; i < MAX_LABELS; i++) begin
								run_q[i] <= '0;
							end
						end else if (q_head.op == OP_FEATURE || q_head.op == OP_END) begin
							if (!open_q) begin
								for (int i = 0; i < MAX_LABELS; i++) begin
									run_q[i] <= '0;
								end
								state_q <= S_OPEN_RD;
							end else if (q_head.op == OP_FEATURE) begin
								state_q <= S_SCAN_RD;
							end else begin
								state_q <= S_END_INIT;
							end
						end
					end
				end
				// default scores: sum of absent weights, stump by stump
				S_OPEN_RD: begin
					if (s_q >= eff_ns) begin
						open_q  <= 1'b1;
						s_q     <= '0;
						l_q     <= '0;
						state_q <= (cur_op_q == OP_FEATURE) ? S_SCAN_RD : S_END_INIT;
					end else if (l_q >= eff_nl) begin
						s_q <= s_q + CSW'(1);
						l_q <= '0;
					end else begin
						state_q <= S_OPEN_ADD;
					end
				end
				S_OPEN_ADD: begin
					run_q[l_q[LW-1:0]] <= sat41((SCORE_W+1)'(cur_run) + (SCORE_W+1)'(wabs_rd_q));
					l_q     <= l_q + CLW'(1);
					state_q <= S_OPEN_RD;
				end
				S_SCAN_RD: begin
					if (s_q >= eff_ns) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (feat_rd_q == cur_feat_q) begin
						below_q <= cur_val_q < thr_rd_q;
						l_q     <= '0;
						state_q <= S_W_RD;
					end else begin
						s_q     <= s_q + CSW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_W_RD: begin
					if (l_q >= eff_nl) begin
						s_q     <= s_q + CSW'(1);
						l_q     <= '0;
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_W_SUB;
					end
				end
				S_W_SUB: begin
					tmp_q   <= sat41((SCORE_W+1)'(cur_run) - (SCORE_W+1)'(wabs_rd_q));
					state_q <= S_W_ADD;
				end
				S_W_ADD: begin
					run_q[l_q[LW-1:0]] <= sat41((SCORE_W+1)'(tmp_q) + (SCORE_W+1)'(w_pick));
					l_q     <= l_q + CLW'(1);
					state_q <= S_W_RD;
				end
				S_END_INIT: begin
					best_q     <= run_q[0];
					best_lbl_q <= '0;
					l_q        <= CLW'(1);
					state_q    <= S_END_CMP;
				end
				S_END_CMP: begin
					if (l_q >= eff_nl) begin
						state_q <= S_EMIT;
					end else begin
						if (cur_run > best_q) begin
							best_q     <= cur_run;
							best_lbl_q <= l_q[LW-1:0];
						end
						l_q <= l_q + CLW'(1);
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						res_label_q <= 3'(best_lbl_q);
						res_score_q <= best_q;
						open_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign labels_reg      = labels_q;
	assign stumps_reg      = stumps_q;
	assign out_valid       = res_valid_q;
	assign predicted_label = res_label_q;
	assign best_score      = res_score_q;

	a_add_after_sub: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W_ADD |-> $past(state_q) == S_W_SUB)
		else $error("score add without preceding subtract");

	a_open_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(open_q) |-> $past(state_q) == S_OPEN_RD)
		else $error("example opened outside default sweep");

	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> !open_q && res_valid_q && state_q == S_IDLE)
		else $error("result emitted but example left open");

	a_label_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W_SUB || state_q == S_W_ADD || state_q == S_OPEN_ADD) |-> l_q < eff_nl)
		else $error("label counter beyond labels in use");

endmodule

// ===== hdl/boosted_stump_classifier.sv =====
// Loads and clear are handled by the back end in its idle state, from the queue head.
// Feature item: the back end scans every stump in use and, for each matching stump,
// updates every label in use; the first item of an example first runs the default sweep.
// End item: labels are compared into the result register. New items wait for idle.
// Reset: scores, open flag and queue clear at once; stump tables stay undefined.
// ----------------------------------------------------------------------------
// boosted_stump_classifier
// Multi-class boosted decision-stump predictor with APB register port.
// ----------------------------------------------------------------------------
module boosted_stump_classifier import bsc_pkg::*; #(
	parameter int MAX_STUMPS   = 256,
	parameter int MAX_LABELS   = 8,
	parameter int FEATURE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                cmd,
	input  logic [7:0]                stump_index,
	input  logic [15:0]               feature_id,
	input  logic signed [31:0]        threshold,
	input  logic [2:0]                label_index,
	input  logic [1:0]                weight_slot,
	input  logic signed [31:0]        weight,
	input  logic signed [31:0]        feature_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                predicted_label,
	output logic signed [SCORE_W-1:0] best_score
);

	cfg_wr_t    cfg_wr;
	logic [3:0] labels_reg;
	logic [8:0] stumps_reg;
	logic       q_full;
	logic       q_push;
	item_t      q_item;
	logic       q_pop;
	logic       q_valid;
	item_t      q_head;

	assign pready      = 1'b1;
	assign cfg_wr.en   = psel && penable && pwrite && pready;
	assign cfg_wr.idx  = paddr[2];
	assign cfg_wr.data = pwdata;

	always_comb begin
		unique case (paddr[2])
			REG_LABELS: prdata = {28'd0, labels_reg};
			default:    prdata = {23'd0, stumps_reg};
		endcase
	end

	bsc_front #(
		.MAX_STUMPS(MAX_STUMPS),
		.MAX_LABELS(MAX_LABELS)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.stump_index  (stump_index),
		.feature_id   (feature_id),
		.threshold    (threshold),
		.label_index  (label_index),
		.weight_slot  (weight_slot),
		.weight       (weight),
		.feature_value(feature_value),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	bsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_item),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	bsc_back #(
		.MAX_STUMPS  (MAX_STUMPS),
		.MAX_LABELS  (MAX_LABELS),
		.FEATURE_BITS(FEATURE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.cfg_wr         (cfg_wr),
		.labels_reg     (labels_reg),
		.stumps_reg     (stumps_reg),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.predicted_label(predicted_label),
		.best_score     (best_score)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the boosted stump classifier: a directed table,
// then phases of random examples and table loads under changing register
// settings. Every result is checked against the bench predictor or a typed value.
// ----------------------------------------------------------------------------
module tb_top;
	import bsc_pkg::*;

	localparam int LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;

	// command and slot codes the block ignores
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam logic [1:0] SLOT_BAD      = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  stump;
		logic [15:0] feat;
		logic [31:0] thr;
		logic [2:0]  label;
		logic [1:0]  slot;
		logic [31:0] wt;
		logic [31:0] fval;
	} req_t;

	typedef struct {
		logic [2:0]  lab;
		logic [39:0] score;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] cmd, label_index, predicted_label;
	logic [7:0] stump_index;
	logic [15:0] feature_id;
	logic signed [31:0] threshold, weight, feature_value;
	logic [1:0] weight_slot;
	logic signed [SCORE_W-1:0] best_score;

	boosted_stump_classifier dut (.*);

	always #6 clk = ~clk;

	// score predictor state
	logic [15:0] feat_tab [256];
	longint thr_tab [256];
	longint w_tab [256][8][3];
	longint def_sc [8];
	longint run_sc [8];
	bit ex_open;
	logic [3:0] labels_q;
	logic [8:0] stumps_q;

	verdict_t verdict_q [$];
	int errors;
	int results_seen;
	longint work_left;
	int burst_left;
	longint cycles;
	logic [15:0] fpool [4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h5A5A};

	function automatic longint sat40(input longint v);
		if (v > 64'sd549755813887) return 64'sd549755813887;
		if (v < -64'sd549755813888) return -64'sd549755813888;
		return v;
	endfunction

	function automatic int eff_nl();
		if (labels_q < 1) return 1;
		if (labels_q > 8) return 8;
		return int'(labels_q);
	endfunction

	function automatic int eff_ns();
		return (stumps_q > 256) ? 256 : int'(stumps_q);
	endfunction

	// generous bound on back-end cycles for an item that gives no result
	function automatic longint item_cost();
		int ns, nl;
		ns = eff_ns();
		nl = eff_nl();
		return 8 + 2 * ns + ns * (3 * nl + 1) + ns * (2 * nl + 1);
	endfunction

	task automatic open_ex();
		int ns, nl;
		ns = eff_ns();
		nl = eff_nl();
		for (int l = 0; l < 8; l++) def_sc[l] = 0;
		for (int s = 0; s < ns; s++)
			for (int l = 0; l < nl; l++) def_sc[l] = sat40(def_sc[l] + w_tab[s][l][SLOT_ABSENT]);
		for (int l = 0; l < 8; l++) run_sc[l] = def_sc[l];
		ex_open = 1'b1;
	endtask

	task automatic model_item(input req_t r, output bit has, output logic [2:0] lab,
			output longint sc);
		int ns, nl, best, pick;
		longint v, val;
		has = 1'b0;
		lab = '0;
		sc = 0;
		case (r.cmd)
			CMD_CLEAR: begin
				for (int l = 0; l < 8; l++) begin
					def_sc[l] = 0;
					run_sc[l] = 0;
				end
				ex_open = 1'b0;
				stumps_q = '0;
			end
			CMD_LOAD_STUMP: begin
				feat_tab[r.stump] = r.feat;
				thr_tab[r.stump] = $signed(r.thr);
			end
			CMD_LOAD_WEIGHT: begin
				if (r.slot <= SLOT_ABOVE) w_tab[r.stump][r.label][r.slot] = $signed(r.wt);
			end
			CMD_FEATURE: begin
				if (!ex_open) open_ex();
				ns = eff_ns();
				nl = eff_nl();
				val = $signed(r.fval);
				for (int s = 0; s < ns; s++) begin
					if (feat_tab[s] == r.feat) begin
						pick = (val < thr_tab[s]) ? SLOT_BELOW : SLOT_ABOVE;
						for (int l = 0; l < nl; l++) begin
							v = sat40(run_sc[l] - w_tab[s][l][SLOT_ABSENT]);
							run_sc[l] = sat40(v + w_tab[s][l][pick]);
						end
					end
				end
			end
			CMD_END: begin
				if (!ex_open) open_ex();
				nl = eff_nl();
				best = 0;
				for (int l = 1; l < nl; l++)
					if (run_sc[l] > run_sc[best]) best = l;
				has = 1'b1;
				lab = best[2:0];
				sc = run_sc[best];
				ex_open = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input req_t r, input bit typed = 1'b0,
			input logic [2:0] tl = '0, input logic [39:0] ts = '0);
		bit has;
		logic [2:0] pl;
		longint ps;
		verdict_t vd;
		int gap;
		cmd <= r.cmd;
		stump_index <= r.stump;
		feature_id <= r.feat;
		threshold <= r.thr;
		label_index <= r.label;
		weight_slot <= r.slot;
		weight <= r.wt;
		feature_value <= r.fval;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		model_item(r, has, pl, ps);
		if (has) begin
			if (typed) begin
				vd.lab = tl;
				vd.score = ts;
			end else begin
				vd.lab = pl;
				vd.score = ps[39:0];
			end
			verdict_q.insert(verdict_q.size(), vd);
		end
		if (r.cmd == CMD_END) work_left = 0;
		else work_left += item_cost();
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait out every pending result and the work still queued behind it
	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (work_left + 20) @(posedge clk);
		work_left = 0;
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= (idx == REG_STUMPS) ? 3'd4 : 3'd0;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_LABELS) labels_q = val[3:0];
		else stumps_q = val[8:0];
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_feat();
		if ($urandom_range(0, 4) != 0) return fpool[$urandom_range(0, 3)];
		return 16'($urandom);
	endfunction

	function automatic req_t rand_base(input logic [2:0] c);
		req_t r;
		r.cmd = c;
		r.stump = 8'($urandom);
		r.feat = 16'($urandom);
		r.thr = $urandom;
		r.label = 3'($urandom);
		r.slot = 2'($urandom);
		r.wt = $urandom;
		r.fval = $urandom;
		return r;
	endfunction

	function automatic req_t mk(input logic [2:0] c, input logic [7:0] st,
			input logic [15:0] f, input logic [31:0] th, input logic [2:0] lb,
			input logic [1:0] sl, input logic [31:0] w, input logic [31:0] fv);
		req_t r;
		r = '{c, st, f, th, lb, sl, w, fv};
		return r;
	endfunction

	task automatic load_tables(input int n, input int nl);
		req_t r;
		for (int s = 0; s < n; s++) begin
			r = rand_base(CMD_LOAD_STUMP);
			r.stump = 8'(s);
			r.feat = pick_feat();
			r.thr = rnd_val();
			send_item(r);
			for (int l = 0; l < nl; l++)
				for (int k = 0; k < 3; k++) begin
					r = rand_base(CMD_LOAD_WEIGHT);
					r.stump = 8'(s);
					r.label = 3'(l);
					r.slot = 2'(k);
					r.wt = ($urandom_range(0, 1) != 0) ? rnd_val() : $urandom;
					send_item(r);
				end
		end
	endtask

	task automatic send_feature(input int span);
		req_t r;
		r = rand_base(CMD_FEATURE);
		r.feat = pick_feat();
		if ($urandom_range(0, 1) != 0)
			r.fval = 32'(thr_tab[$urandom_range(0, span - 1)] + $urandom_range(0, 2) - 1);
		else
			r.fval = rnd_val();
		send_item(r);
	endtask

	task automatic send_noise();
		req_t r;
		case ($urandom_range(0, 39))
			0: r = rand_base(CMD_CLEAR);
			1, 2, 3, 4: r = rand_base(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
			5, 6, 7, 8, 9, 10, 11, 12: r = rand_base(CMD_LOAD_STUMP);
			default: begin
				r = rand_base(CMD_LOAD_WEIGHT);
				r.wt = rnd_val();
			end
		endcase
		send_item(r);
	endtask

	// mostly well-formed examples, some left open, plus loads, clears and junk commands
	task automatic run_random(input int n, input int span);
		int sent, len;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) < 7) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0) send_noise();
					else send_feature(span);
					sent++;
				end
				if ($urandom_range(0, 9) != 0) begin
					send_item(rand_base(CMD_END));
					sent++;
				end
			end else begin
				send_noise();
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		verdict_t vd;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (verdict_q.size() == 0) begin
				$display("%0t unexpected result: label %0d score %0d", $time,
					predicted_label, best_score);
				errors++;
			end else begin
				vd = verdict_q.pop_front();
				if (vd.lab !== predicted_label) begin
					$display("%0t predicted_label mismatch: expected %0d, actual %0d", $time,
						vd.lab, predicted_label);
					errors++;
				end
				if (vd.score !== best_score) begin
					$display("%0t best_score mismatch: expected %0d, actual %0d", $time,
						$signed(vd.score), best_score);
					errors++;
				end
			end
		end
	end

	// receiver: changing stall patterns and one long hold-off
	initial begin
		int mode, span, tick;
		bit held;
		held = 1'b0;
		tick = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(posedge clk);
				tick++;
				if (!held && results_seen >= 20) begin
					held = 1'b1;
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= $urandom_range(0, 1);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= (tick % 8) < 3;
					endcase
				end
			end
		end
	end

	initial begin
		req_t tab [9];
		int lab_set [12] = '{8, 1, 0, 15, 3, 9, 2, 5, 4, 7, 6, 12};
		int stp_set [12] = '{16, 1, 0, 16, 5, 16, 3, 8, 12, 16, 2, 10};
		errors = 0;
		results_seen = 0;
		work_left = 0;
		burst_left = 1;
		cycles = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= '0;
		stump_index <= '0;
		feature_id <= '0;
		threshold <= '0;
		label_index <= '0;
		weight_slot <= '0;
		weight <= '0;
		feature_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int s = 0; s < 256; s++) begin
			feat_tab[s] = '0;
			thr_tab[s] = 0;
			for (int l = 0; l < 8; l++)
				for (int k = 0; k < 3; k++) w_tab[s][l][k] = 0;
		end
		for (int l = 0; l < 8; l++) begin
			def_sc[l] = 0;
			run_sc[l] = 0;
		end
		ex_open = 1'b0;
		labels_q = 4'd8;
		stumps_q = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no stumps in use: every example ends on label 0 with a zero score
		send_item(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, 3'd0, 40'd0);
		send_item(mk(CMD_FEATURE, 0, 16'hFFFF, 0, 0, 0, 0, 32'h8000_0000));
		send_item(mk(CMD_UNUSED_LO, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, SLOT_BAD,
			32'hFFFF_FFFF, 0));
		send_item(mk(CMD_UNUSED_HI, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
		send_item(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, 3'd0, 40'd0);
		send_item(mk(CMD_LOAD_STUMP, 8'hFF, 16'hFFFF, 32'h8000_0000, 0, 0, 0, 0));
		send_item(mk(CMD_LOAD_STUMP, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		send_item(mk(CMD_LOAD_WEIGHT, 0, 0, 0, 3'd7, SLOT_BAD, 32'h7FFF_FFFF, 0));
		send_item(mk(CMD_LOAD_WEIGHT, 8'hFF, 0, 0, 3'd7, SLOT_ABOVE, 32'h8000_0000, 0));
		send_item(mk(CMD_FEATURE, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, 3'd0, 40'd0);
		drain();

		load_tables(16, 8);
		drain();
		reg_write(REG_STUMPS, 32'd2);

		// repeated features, both sides of the threshold, a load mid-example
		tab[0] = mk(CMD_END, 0, 0, 0, 0, 0, 0, 0);
		tab[1] = mk(CMD_FEATURE, 0, feat_tab[0], 0, 0, 0, 0, 32'h8000_0000);
		tab[2] = mk(CMD_FEATURE, 0, feat_tab[0], 0, 0, 0, 0, 32'h8000_0000);
		tab[3] = mk(CMD_FEATURE, 0, feat_tab[0], 0, 0, 0, 0, 32'h7FFF_FFFF);
		tab[4] = mk(CMD_FEATURE, 0, feat_tab[1], 0, 0, 0, 0, 32'(thr_tab[1]));
		tab[5] = mk(CMD_LOAD_WEIGHT, 0, 0, 0, 0, SLOT_ABSENT, 32'h7FFF_FFFF, 0);
		tab[6] = mk(CMD_FEATURE, 0, feat_tab[0], 0, 0, 0, 0, 32'(thr_tab[0] - 1));
		tab[7] = mk(CMD_END, 0, 0, 0, 0, 0, 0, 0);
		tab[8] = mk(CMD_FEATURE, 0, feat_tab[1], 0, 0, 0, 0, 32'h0);
		foreach (tab[i]) send_item(tab[i]);
		drain();
		// label count changes while the example is still open
		reg_write(REG_LABELS, 32'd3);
		send_item(mk(CMD_FEATURE, 0, feat_tab[0], 0, 0, 0, 0, 32'h0));
		send_item(mk(CMD_END, 0, 0, 0, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < 12; p++) begin
			reg_write(REG_LABELS, lab_set[p]);
			reg_write(REG_STUMPS, stp_set[p]);
			run_random(15, 16);
			drain();
		end

		// full table, single label
		reg_write(REG_LABELS, 32'd1);
		load_tables(256, 1);
		drain();
		reg_write(REG_STUMPS, 32'd256);
		run_random(40, 256);
		drain();
		reg_write(REG_LABELS, 32'd0);
		reg_write(REG_STUMPS, 32'd511);
		run_random(40, 256);
		drain();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== boosted_stump_classifier.f =====
hdl/bsc_pkg.sv
hdl/bsc_front.sv
hdl/bsc_queue.sv
hdl/bsc_back.sv
hdl/boosted_stump_classifier.sv
verif/tb_top.sv
